>>> hdl/csma_channel_access_core_defines.svh
// Assertion helpers shared by the channel-access core.
`ifndef CSMA_CHANNEL_ACCESS_CORE_DEFINES_SVH
`define CSMA_CHANNEL_ACCESS_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CSMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CSMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/csma_pkg.sv
`timescale 1ns / 1ps

package csma_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned RandFieldW = 32;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned PercentW   = 7;
  localparam int unsigned SpanW      = 10;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned LeftW      = 10;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned CntExtW    = 16;

  // Modulus of the persistence check
  localparam logic [PercentW-1:0] PercentScale = 7'd100;

  // Register reset values
  localparam logic [ModeW-1:0]    ModeReset    = 2'd2;
  localparam logic [PercentW-1:0] PercentReset = 7'd50;
  localparam logic [SpanW-1:0]    SpanReset    = 10'd1000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegAccessMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSendPercent = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBackoffSpan = 2'd2;

  // Access modes
  localparam logic [ModeW-1:0] ModeOnePersist = 2'd1;

  // Result status codes
  localparam logic [StatusW-1:0] StatIdle    = 3'd0;
  localparam logic [StatusW-1:0] StatSent    = 3'd1;
  localparam logic [StatusW-1:0] StatBackoff = 3'd2;
  localparam logic [StatusW-1:0] StatWaitClr = 3'd3;
  localparam logic [StatusW-1:0] StatRefused = 3'd4;

  // Request kinds
  localparam logic ReqSend = 1'b0;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_COMMIT
  } csma_fsm_e;

endpackage

>>> hdl/csma_channel_access_core.sv
// Each item runs through the bit-serial remainder units, which reduce both random
// words (RAND_WIDTH bits, capped at 32) one bit per cycle; a new item is taken
// only after the result of the last one is committed.
// Reset (rst_ni low, asynchronous): no frame pending, backoff count 0, mode
// p-persistent, send percent 50, backoff span 1000, no result held.
`timescale 1ns / 1ps

`include "csma_channel_access_core_defines.svh"

module csma_channel_access_core import csma_pkg::*; #(
  parameter int unsigned RAND_WIDTH    = 32,
  parameter int unsigned BACKOFF_WIDTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: channel_clear[0], rand_prob[32:1], rand_delay[64:33], zero fill[71:65]
  input  logic [71:0]         s_axis_tdata,
  // tuser: req_type[0]
  input  logic [0:0]          s_axis_tuser,
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: transmit[0], status[3:1], backoff_left[13:4], zero fill[15:14]
  output logic [15:0]         m_axis_tdata
);

  localparam int unsigned RandW = (RAND_WIDTH < RandFieldW) ? RAND_WIDTH : RandFieldW;
  localparam int unsigned CntW  = BACKOFF_WIDTH;

  csma_fsm_e           state_q, state_d;
  logic [ModeW-1:0]    mode_q;
  logic [PercentW-1:0] percent_q;
  logic [SpanW-1:0]    span_q;
  logic                pending_q, pending_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                tick_q;
  logic                clear_q;
  logic                out_valid_q;
  logic [15:0]         out_data_q;
  logic                in_xfer;
  logic                out_free;
  logic                commit;
  logic                p_done, d_done;
  logic [PercentW-1:0] rem_p;
  logic [SpanW-1:0]    rem_d;
  logic [CntExtW-1:0]  rem_d_ext;
  logic [CntExtW-1:0]  count_ext;
  logic [CntW-1:0]     dec_count;
  logic                do_attempt;
  logic                go;
  logic [StatusW-1:0]  status;
  logic [LeftW-1:0]    left;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == FSM_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Remainder of rand_prob by the percent scale
  csma_rem_unit #(
    .DATA_W (RandW),
    .DIV_W  (PercentW)
  ) u_rem_prob (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .dividend_i (s_axis_tdata[RandW:1]),
    .divisor_i  (PercentScale),
    .done_o     (p_done),
    .rem_o      (rem_p)
  );

  // Remainder of rand_delay by the backoff span
  csma_rem_unit #(
    .DATA_W (RandW),
    .DIV_W  (SpanW)
  ) u_rem_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .dividend_i (s_axis_tdata[RandFieldW+RandW:RandFieldW+1]),
    .divisor_i  (span_q),
    .done_o     (d_done),
    .rem_o      (rem_d)
  );

  // Sequence the item and resolve the access decision at commit
  always_comb begin
    state_d    = state_q;
    commit     = 1'b0;
    pending_d  = pending_q;
    count_d    = count_q;
    status     = StatIdle;
    do_attempt = 1'b0;
    go         = 1'b0;
    rem_d_ext  = CntExtW'(rem_d);
    dec_count  = (count_q != '0) ? (count_q - CntW'(1)) : '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer) state_d = FSM_RUN;
      end
      FSM_RUN: begin
        if (p_done) state_d = FSM_COMMIT;
      end
      FSM_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase

    // Decide what this item does to the pending frame
    if (tick_q == ReqSend) begin
      if (pending_q) begin
        status = StatRefused;
      end else begin
        pending_d  = 1'b1;
        count_d    = '0;
        do_attempt = 1'b1;
      end
    end else if (!pending_q) begin
      status = StatIdle;
    end else begin
      count_d = dec_count;
      if (dec_count == '0) begin
        do_attempt = 1'b1;
      end else begin
        status = StatBackoff;
      end
    end

    if (do_attempt) begin
      go = clear_q && (!mode_q[1] || (rem_p < percent_q));
      if (go) begin
        pending_d = 1'b0;
        count_d   = '0;
        status    = StatSent;
      end else if (mode_q == ModeOnePersist) begin
        count_d = '0;
        status  = StatWaitClr;
      end else begin
        count_d = (span_q != '0) ? rem_d_ext[CntW-1:0] : '0;
        status  = StatBackoff;
      end
    end

    count_ext = CntExtW'(count_d);
    left      = pending_d ? count_ext[LeftW-1:0] : '0;
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      mode_q      <= ModeReset;
      percent_q   <= PercentReset;
      span_q      <= SpanReset;
      pending_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegAccessMode:  mode_q    <= cfg_data_i[ModeW-1:0];
          RegSendPercent: percent_q <= cfg_data_i[PercentW-1:0];
          RegBackoffSpan: span_q    <= cfg_data_i[SpanW-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        pending_q   <= pending_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the item kind and carrier sense; load the result on commit
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q  <= s_axis_tuser[0];
      clear_q <= s_axis_tdata[0];
    end
    if (commit) begin
      out_data_q <= {2'b00, left, status, (status == StatSent)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CSMA_ASSERT_SAME(a_idle_count_zero, !pending_q, count_q == '0, "count set with no frame pending")
  `CSMA_ASSERT_SAME(a_units_in_step, p_done || d_done, p_done && d_done && state_q == FSM_RUN, "remainder units out of step")
  `CSMA_ASSERT_SAME(a_tx_matches_status, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == StatSent), "transmit flag disagrees with status")
  `CSMA_ASSERT_NEXT(a_commit_frees_input, commit, s_axis_tready && m_axis_tvalid, "commit did not return to idle")

endmodule

>>> hdl/csma_rem_unit.sv
`timescale 1ns / 1ps

// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module csma_rem_unit import csma_pkg::*; #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DIV_W  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] shreg_q, shreg_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and subtract when the divisor fits
  always_comb begin
    trial = {rem_q, shreg_q[DATA_W-1]};
    fits  = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
  end

  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shreg_d = dividend_i;
      rem_d   = '0;
      cnt_d   = CntW'(DATA_W);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shreg_d = {shreg_q[DATA_W-2:0], 1'b0};
      rem_d   = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import csma_pkg::*;

  // Codes the package leaves unnamed
  localparam logic             ReqTick        = 1'b1;
  localparam logic [ModeW-1:0] ModeNonPersist = 2'd0;
  localparam logic [ModeW-1:0] ModePPersist   = 2'd2;
  localparam logic [ModeW-1:0] ModeReserved   = 2'd3;

  localparam int SettleCycles = 40;
  localparam int RxStallCycles = 400;
  localparam int ItemsPerPhase = 45;

  typedef struct packed {
    logic                  req;
    logic                  clear;
    logic [RandFieldW-1:0] rp;
    logic [RandFieldW-1:0] rd;
  } access_req_t;

  typedef struct packed {
    logic               transmit;
    logic [StatusW-1:0] status;
    logic [LeftW-1:0]   left;
  } access_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [71:0]         s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;

  // Predicted block state and registers
  logic                frame_pend = 1'b0;
  logic [LeftW-1:0]    backoff_cnt = '0;
  logic [ModeW-1:0]    cfg_mode = ModeReset;
  logic [PercentW-1:0] cfg_pct = PercentReset;
  logic [SpanW-1:0]    cfg_span = SpanReset;

  access_req_t req_q[$];
  access_req_t req_cur;
  access_res_t res_exp_q[$];

  int  tx_idle_pct = 17;
  int  rx_idle_pct = 45;
  logic rx_stall = 1'b0;

  int err_cnt = 0;
  int n_in = 0;
  int n_cfg = 0;
  int n_sent = 0;
  int n_backoff = 0;
  int n_waitclr = 0;
  int n_refused = 0;
  int n_idle = 0;

  logic [ModeW-1:0] mode_seq [4] = '{ModeNonPersist, ModeOnePersist, ModePPersist, ModeReserved};

  csma_channel_access_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // One transmit attempt: send, wait for a clear channel, or draw a backoff
  function automatic logic [StatusW-1:0] try_send(access_req_t rq);
    logic go;
    go = rq.clear;
    if (cfg_mode >= ModePPersist && rq.clear)
      go = (rq.rp % {25'd0, PercentScale}) < {25'd0, cfg_pct};
    if (go) begin
      frame_pend = 1'b0;
      backoff_cnt = '0;
      return StatSent;
    end
    if (cfg_mode == ModeOnePersist) begin
      backoff_cnt = '0;
      return StatWaitClr;
    end
    backoff_cnt = (cfg_span != '0) ? LeftW'(rq.rd % {22'd0, cfg_span}) : '0;
    return StatBackoff;
  endfunction

  // Advance the predicted state by one accepted request or tick
  function automatic access_res_t predict_access(access_req_t rq);
    access_res_t r;
    if (rq.req == ReqSend) begin
      if (frame_pend) begin
        r.status = StatRefused;
      end else begin
        frame_pend = 1'b1;
        backoff_cnt = '0;
        r.status = try_send(rq);
      end
    end else if (!frame_pend) begin
      r.status = StatIdle;
    end else begin
      if (backoff_cnt != '0) backoff_cnt = backoff_cnt - LeftW'(1);
      r.status = (backoff_cnt == '0) ? try_send(rq) : StatBackoff;
    end
    r.transmit = (r.status == StatSent);
    r.left = frame_pend ? backoff_cnt : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0d at %0t: %s got %0d want %0d", err_cnt + 1, $realtime, what, got,
             want);
    err_cnt++;
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_result(logic [15:0] d);
    access_res_t e;
    if (res_exp_q.size() == 0) begin
      report_mismatch("result with nothing outstanding, status", int'(d[3:1]), 0);
      return;
    end
    e = res_exp_q.pop_front();
    if (d[0] !== e.transmit) report_mismatch("transmit", int'(d[0]), int'(e.transmit));
    if (d[3:1] !== e.status) report_mismatch("status", int'(d[3:1]), int'(e.status));
    if (d[13:4] !== e.left) report_mismatch("backoff_left", int'(d[13:4]), int'(e.left));
    case (e.status)
      StatSent:    n_sent++;
      StatBackoff: n_backoff++;
      StatWaitClr: n_waitclr++;
      StatRefused: n_refused++;
      default:     n_idle++;
    endcase
  endtask

  // Driver: predict on each input transfer, then offer the next queued item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        res_exp_q.push_back(predict_access(req_cur));
        n_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_cur = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, req_cur.rd, req_cur.rp, req_cur.clear};
          s_axis_tuser <= req_cur.req;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, stall at random or on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= !rx_stall && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_item(logic req, logic clear, logic [RandFieldW-1:0] rp,
                           logic [RandFieldW-1:0] rd);
    access_req_t it;
    it.req = req;
    it.clear = clear;
    it.rp = rp;
    it.rd = rd;
    req_q.push_back(it);
  endtask

  // Wait until every queued item is taken and every result has come back
  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || res_exp_q.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegAccessMode:  cfg_mode = data[ModeW-1:0];
      RegSendPercent: cfg_pct = data[PercentW-1:0];
      RegBackoffSpan: cfg_span = data[SpanW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Reconfigure only with nothing in flight
  task automatic set_config(logic [ModeW-1:0] mode, logic [PercentW-1:0] pct,
                            logic [SpanW-1:0] span);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_write(RegAccessMode, CfgDataW'(mode));
    cfg_write(RegSendPercent, CfgDataW'(pct));
    cfg_write(RegBackoffSpan, span);
    @(negedge clk_i);
  endtask

  // Mostly a request followed by a run of ticks, with some stray items
  task automatic rand_phase(int n_items);
    int n;
    int k;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(9) == 0) begin
        push_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
        n++;
      end else begin
        push_item(ReqSend, $urandom_range(9) < 6, $urandom, $urandom);
        k = $urandom_range(cfg_span + 4, 1);
        repeat (k) push_item(ReqTick, $urandom_range(9) < 7, $urandom, $urandom);
        n += k + 1;
      end
    end
  endtask

  initial begin
    logic [PercentW-1:0] pct;
    logic [SpanW-1:0] span;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: idle tick, send, percent boundary, refusal, zero backoff
    push_item(ReqTick, 1'b1, 32'd0, 32'd0);
    push_item(ReqSend, 1'b1, 32'd0, 32'd0);
    push_item(ReqSend, 1'b1, 32'hFFFF_FFFF, 32'd1003);
    push_item(ReqTick, 1'b1, 32'd0, 32'd0);
    push_item(ReqSend, 1'b1, 32'd0, 32'd0);
    push_item(ReqTick, 1'b0, 32'd0, 32'd0);
    push_item(ReqTick, 1'b0, 32'd0, 32'd1000);
    push_item(ReqTick, 1'b1, 32'd49, 32'd0);
    push_item(ReqTick, 1'b1, 32'd0, 32'd0);
    push_item(ReqSend, 1'b1, 32'd50, 32'd0);
    push_item(ReqTick, 1'b1, 32'd149, 32'hFFFF_FFFF);

    // One-persistent: wait for a clear channel, no backoff
    set_config(ModeOnePersist, 7'd0, 10'd5);
    push_item(ReqSend, 1'b0, 32'd0, 32'hFFFF_FFFF);
    push_item(ReqTick, 1'b0, 32'd0, 32'hFFFF_FFFF);
    push_item(ReqTick, 1'b1, 32'd99, 32'd0);

    // Non-persistent: zero and full backoff, count down to a send
    set_config(ModeNonPersist, 7'd100, 10'd5);
    push_item(ReqSend, 1'b0, 32'd0, 32'hFFFF_FFFF);
    push_item(ReqTick, 1'b1, 32'hFFFF_FFFF, 32'd0);
    push_item(ReqSend, 1'b0, 32'd0, 32'd4);
    repeat (4) push_item(ReqTick, 1'b1, 32'd0, 32'd0);

    // Reserved mode, percent above hundred, span zero
    set_config(ModeReserved, 7'd127, 10'd0);
    push_item(ReqSend, 1'b1, 32'hFFFF_FFFF, 32'd0);
    push_item(ReqSend, 1'b0, 32'd0, 32'hFFFF_FFFF);
    push_item(ReqTick, 1'b1, 32'd99, 32'hFFFF_FFFF);

    // Random phases under each idling pattern
    for (int s = 0; s < 3; s++) begin
      for (int p = 0; p < 6; p++) begin
        case (p)
          0: pct = 7'd0;
          1: pct = 7'd100;
          2: pct = 7'd127;
          default: pct = PercentW'($urandom_range(100));
        endcase
        case (p)
          3: span = 10'd0;
          4: span = 10'd1;
          default: span = SpanW'($urandom_range(12, 1));
        endcase
        set_config(mode_seq[p % 4], pct, span);
        if (s == 0 && p == 0) begin
          // Hold off the receiver so the block backs up into its input
          fork
            begin
              rx_stall <= 1'b1;
              repeat (RxStallCycles) @(posedge clk_i);
              rx_stall <= 1'b0;
            end
          join_none
        end
        rand_phase(ItemsPerPhase);
      end
      drain();
      case (s)
        0: begin
          tx_idle_pct = 45;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
    end

    // Longest backoff: clear any pending frame, then draw the largest count
    set_config(ModeNonPersist, 7'd50, 10'd1023);
    while (frame_pend) begin
      push_item(ReqTick, 1'b1, $urandom, $urandom);
      drain();
    end
    push_item(ReqSend, 1'b0, $urandom, 32'd1022);
    repeat (3) push_item(ReqTick, 1'b1, $urandom, $urandom);
    push_item(ReqSend, 1'b1, $urandom, $urandom);
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d items and %0d register writes over all four modes", n_in, n_cfg);
    $display("results: %0d sent, %0d backoff, %0d waiting, %0d refused, %0d idle", n_sent,
             n_backoff, n_waitclr, n_refused, n_idle);
    if (err_cnt == 0 && res_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", res_exp_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
